// ===== rtl/psfc_pkg.sv =====
// Shared format codes, register map and format helpers for the PCM sample format codec.
`default_nettype none

package psfc_pkg;

    // Packed sample formats held in the format register.
    localparam logic [2:0] FMT_U8     = 3'd0;
    localparam logic [2:0] FMT_S16LE  = 3'd1;
    localparam logic [2:0] FMT_S16BE  = 3'd2;
    localparam logic [2:0] FMT_S24LE  = 3'd3;
    localparam logic [2:0] FMT_S24BE  = 3'd4;
    localparam logic [2:0] FMT_S32LE  = 3'd5;
    localparam logic [2:0] FMT_S32BE  = 3'd6;
    localparam logic [2:0] FMT_F32LE  = 3'd7;

    localparam logic [2:0] FMT_RESET  = FMT_S16LE;

    // Operation codes carried by each input beat.
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // Register map: one 32-bit register per word, word index in paddr[2].
    localparam int unsigned PADDR_W     = 3;
    localparam logic        REG_PCM_FMT = 1'b0;

    // Bytes per sample for a format.
    function automatic logic [2:0] fmt_bytes(input logic [2:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_U8:                 n = 3'd1;
            FMT_S16LE, FMT_S16BE:   n = 3'd2;
            FMT_S24LE, FMT_S24BE:   n = 3'd3;
            default:                n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pcm_sample_format_codec.sv =====
// Top level of the PCM sample format codec: register port, input stage and result stage.
//
// The block converts one audio sample per beat between a packed PCM word and a
// signed Q1.31 value. An input beat carries op, packed_in and sample_in; op
// selects decode (packed_in to sample_out) or encode (sample_in to packed_out).
// Each input beat yields exactly one result beat carrying sample_out,
// packed_out and byte_count; the field that the operation does not produce
// reads as zero.
// The packed format lives in a single APB register at byte address 0 and
// should only be written while no beats are in flight.
// A beat accepted at a clock edge sits in the input register, and then
// passes through the conversion logic into the result register, where
// out_valid rises. Throughput is one beat per cycle while the receiver
// keeps up; the conversion path is a single combinational pass, with the
// float normalize as its longest part.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat, so in_ready drops only once both stages
// are full.
// Reset clears both stage valid flags and sets the format to s16le.
`default_nettype none

module pcm_sample_format_codec (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psfc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [31:0]                   packed_in,
    input  wire logic signed [31:0]            sample_in,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 sample_out,
    output logic      [31:0]                   packed_out,
    output logic      [2:0]                    byte_count
);
    import psfc_pkg::*;

    // Format register.
    logic [2:0]  fmt_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PCM_FMT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fmt_reg <= FMT_RESET;
        end else if (cfg_wr) begin
            fmt_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == REG_PCM_FMT) ? {29'd0, fmt_reg} : 32'd0;

    // Input stage. The format is captured with each beat so the result
    // always matches the format that was current at acceptance.
    logic        a_valid_reg;
    logic        a_op_reg;
    logic [31:0] a_packed_reg;
    logic [31:0] a_sample_reg;
    logic [2:0]  a_fmt_reg;
    logic        b_ready;
    logic        a_load;
    logic        a_move;

    assign b_ready  = !out_valid || out_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign a_load   = in_valid && in_ready;
    assign a_move   = a_valid_reg && b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load) begin
            a_op_reg     <= op;
            a_packed_reg <= packed_in;
            a_sample_reg <= sample_in;
            a_fmt_reg    <= fmt_reg;
        end
    end

    // Conversion logic.
    logic [31:0] dec_sample;
    logic [31:0] enc_packed;
    logic [31:0] sample_next;
    logic [31:0] packed_next;

    psfc_decoder u_decoder (
        .fmt         (a_fmt_reg),
        .packed_word (a_packed_reg),
        .sample      (dec_sample)
    );

    psfc_encoder u_encoder (
        .fmt         (a_fmt_reg),
        .sample      (a_sample_reg),
        .packed_word (enc_packed)
    );

    assign sample_next = (a_op_reg == OP_DECODE) ? dec_sample : 32'd0;
    assign packed_next = (a_op_reg == OP_ENCODE) ? enc_packed : 32'd0;

    // Result stage.
    logic        out_valid_reg;
    logic [31:0] sample_out_reg;
    logic [31:0] packed_out_reg;
    logic [2:0]  byte_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (b_ready) begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move) begin
            sample_out_reg <= sample_next;
            packed_out_reg <= packed_next;
            byte_count_reg <= fmt_bytes(a_fmt_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign packed_out = packed_out_reg;
    assign byte_count = byte_count_reg;

endmodule

`default_nettype wire

// ===== rtl/psfc_decoder.sv =====
// Decoder from packed PCM bytes to a signed Q1.31 sample.
`default_nettype none

module psfc_decoder (
    input  wire logic [2:0]  fmt,
    input  wire logic [31:0] packed_word,
    output logic      [31:0] sample
);
    import psfc_pkg::*;

    logic [7:0]  b0, b1, b2, b3;
    logic        f_neg;
    logic [7:0]  f_exp;
    logic [22:0] f_frac;
    logic [23:0] f_mant;
    logic [7:0]  f_eexp;
    logic [7:0]  f_rsh;
    logic [31:0] f_shifted;
    logic [31:0] f_mag;
    logic [31:0] f_q31;

    assign b0 = packed_word[7:0];
    assign b1 = packed_word[15:8];
    assign b2 = packed_word[23:16];
    assign b3 = packed_word[31:24];

    assign f_neg  = packed_word[31];
    assign f_exp  = packed_word[30:23];
    assign f_frac = packed_word[22:0];

    // Subnormals use exponent one with no hidden bit.
    assign f_mant  = (f_exp != 8'd0) ? {1'b1, f_frac} : {1'b0, f_frac};
    assign f_eexp  = (f_exp != 8'd0) ? f_exp : 8'd1;
    // Right shift of mant*2^8 that lands on twice the Q1.31 value; only used
    // for exponents below 127.
    assign f_rsh   = 8'd126 - f_eexp;

    always_comb
    begin
        // One extra low bit keeps the rounding bit; add it back for ties away from zero.
        if (f_rsh >= 8'd32) begin
            f_shifted = 32'd0;
        end else begin
            f_shifted = {f_mant, 8'd0} >> f_rsh[4:0];
        end
        f_mag = {1'b0, f_shifted[31:1]} + {31'd0, f_shifted[0]};
    end

    always_comb
    begin
        if (f_exp == 8'hFF || (f_exp == 8'd0 && f_frac == 23'd0)) begin
            f_q31 = 32'd0;
        end else if (f_exp >= 8'd127) begin
            f_q31 = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            f_q31 = f_neg ? (32'd0 - f_mag) : f_mag;
        end
    end

    always_comb
    begin
        unique case (fmt)
            FMT_U8:    sample = {b0 ^ 8'h80, 24'd0};
            FMT_S16LE: sample = {b1, b0, 16'd0};
            FMT_S16BE: sample = {b0, b1, 16'd0};
            FMT_S24LE: sample = {b2, b1, b0, 8'd0};
            FMT_S24BE: sample = {b0, b1, b2, 8'd0};
            FMT_S32LE: sample = packed_word;
            FMT_S32BE: sample = {b0, b1, b2, b3};
            FMT_F32LE: sample = f_q31;
            default:   sample = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/psfc_encoder.sv =====
// Encoder from a signed Q1.31 sample to packed PCM bytes.
`default_nettype none

module psfc_encoder (
    input  wire logic [2:0]  fmt,
    input  wire logic [31:0] sample,
    output logic      [31:0] packed_word
);
    import psfc_pkg::*;

    // Rounds s / 2^k half away from zero and saturates to a signed (32-k)-bit value.
    function automatic logic [32:0] round_sat(input logic [31:0] s, input int unsigned k);
        logic [32:0] mag;
        logic [32:0] sum;
        logic [32:0] qm;
        logic [32:0] lim;
        logic [32:0] q;
        mag = s[31] ? (33'd0 - {1'b1, s}) : {1'b0, s};
        sum = mag + (33'd1 << (k - 1));
        qm  = sum >> k;
        lim = 33'd1 << (31 - k);
        if (!s[31]) begin
            q = (qm >= lim) ? (lim - 33'd1) : qm;
        end else begin
            q = (qm >= lim) ? (33'd0 - lim) : (33'd0 - qm);
        end
        return q;
    endfunction

    logic [32:0] r8, r16, r24;
    logic [7:0]  q8;
    logic [15:0] q16;
    logic [23:0] q24;

    assign r8  = round_sat(sample, 24);
    assign r16 = round_sat(sample, 16);
    assign r24 = round_sat(sample, 8);
    assign q8  = r8[7:0] ^ 8'h80;
    assign q16 = r16[15:0];
    assign q24 = r24[23:0];

    // Single precision, round to nearest even, via a five-step normalizing shift.
    logic        neg;
    logic [31:0] mag;
    logic [31:0] norm;
    logic [4:0]  lz;
    logic        guard;
    logic        sticky;
    logic        inc;
    logic [24:0] mant_r;
    logic [7:0]  exp_r;
    logic [31:0] f32;

    assign neg = sample[31];
    assign mag = neg ? (32'd0 - sample) : sample;

    always_comb
    begin
        norm = mag;
        lz   = 5'd0;
        if (norm[31:16] == 16'd0) begin
            norm  = norm << 16;
            lz[4] = 1'b1;
        end
        if (norm[31:24] == 8'd0) begin
            norm  = norm << 8;
            lz[3] = 1'b1;
        end
        if (norm[31:28] == 4'd0) begin
            norm  = norm << 4;
            lz[2] = 1'b1;
        end
        if (norm[31:30] == 2'd0) begin
            norm  = norm << 2;
            lz[1] = 1'b1;
        end
        if (norm[31] == 1'b0) begin
            norm  = norm << 1;
            lz[0] = 1'b1;
        end
    end

    assign guard  = norm[7];
    assign sticky = |norm[6:0];
    assign inc    = guard & (sticky | norm[8]);
    assign mant_r = {1'b0, norm[31:8]} + {24'd0, inc};
    assign exp_r  = 8'd127 - {3'd0, lz} + {7'd0, mant_r[24]};

    always_comb
    begin
        if (mag == 32'd0) begin
            f32 = 32'd0;
        end else if (mant_r[24]) begin
            f32 = {neg, exp_r, 23'd0};
        end else begin
            f32 = {neg, exp_r, mant_r[22:0]};
        end
    end

    always_comb
    begin
        unique case (fmt)
            FMT_U8:    packed_word = {24'd0, q8};
            FMT_S16LE: packed_word = {16'd0, q16};
            FMT_S16BE: packed_word = {16'd0, q16[7:0], q16[15:8]};
            FMT_S24LE: packed_word = {8'd0, q24};
            FMT_S24BE: packed_word = {8'd0, q24[7:0], q24[15:8], q24[23:16]};
            FMT_S32LE: packed_word = sample;
            FMT_S32BE: packed_word = {sample[7:0], sample[15:8], sample[23:16], sample[31:24]};
            FMT_F32LE: packed_word = f32;
            default:   packed_word = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/psfc_checker.sv =====
// Port-level checker for the PCM sample format codec, bound to the top level.
`default_nettype none

module psfc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] sample_out,
    input  wire logic [31:0] packed_out,
    input  wire logic [2:0]  byte_count
);

    // With the result stage empty, the input side must be able to take a beat.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low while no result is pending");

    // A result carries either a decoded sample or encoded bytes, never both.
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_out == 32'd0 || packed_out == 32'd0))
        else $error("result carries both sample and packed data");

    // The byte count always names a real sample size.
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count >= 3'd1 && byte_count <= 3'd4))
        else $error("byte_count out of range");

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
            && $stable(packed_out) && $stable(byte_count))
        else $error("result beat changed while stalled");

endmodule

bind pcm_sample_format_codec psfc_checker u_psfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .packed_out (packed_out),
    .byte_count (byte_count)
);

`default_nettype wire

// ===== sim/pcm_codec_checker.sv =====
// Checker for the PCM sample format codec: tracks the format register, predicts and compares results.
module pcm_codec_checker
    import psfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,

    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 op,
    input  logic [31:0]          packed_in,
    input  logic signed [31:0]   sample_in,

    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic signed [31:0]   sample_out,
    input  logic [31:0]          packed_out,
    input  logic [2:0]           byte_count,

    output int                   fail_count,
    output int                   outstanding
);

    typedef struct {
        logic [31:0] sample_v;
        logic [31:0] word_v;
        logic [2:0]  count_v;
    } conversion_t;

    conversion_t pending_conversions[$];
    logic [2:0]  cur_format;

    function automatic int bytes_per_sample(logic [2:0] f);
        case (f)
            FMT_U8:               return 1;
            FMT_S16LE, FMT_S16BE: return 2;
            FMT_S24LE, FMT_S24BE: return 3;
            default:              return 4;
        endcase
    endfunction

    // Collect n bytes of a transmit-order word into a value, first byte most significant if big.
    function automatic logic [31:0] gather_bytes(logic [31:0] w, int n, bit big);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            if (big)
                v = (v << 8) | {24'd0, w[8*i +: 8]};
            else
                v[8*i +: 8] = w[8*i +: 8];
        end
        return v;
    endfunction

    function automatic logic [31:0] scatter_bytes(logic [31:0] v, int n, bit big);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < n; i++)
            w[8*i +: 8] = big ? v[8*(n-1-i) +: 8] : v[8*i +: 8];
        return w;
    endfunction

    function automatic logic [31:0] float_to_fixed(logic [31:0] b);
        logic        neg;
        logic [7:0]  e;
        logic [22:0] f;
        logic [31:0] m;
        logic [31:0] mag;
        int          ee;
        int          s;
        neg = b[31];
        e   = b[30:23];
        f   = b[22:0];
        if (e == 8'hFF || (e == 8'd0 && f == 23'd0))
            return 32'd0;
        if (e >= 8'd127)
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m  = (e != 8'd0) ? {8'd0, 1'b1, f} : {9'd0, f};
        ee = (e != 8'd0) ? int'(e) : 1;
        if (ee >= 119) begin
            mag = m << (ee - 119);
        end
        else begin
            s   = 119 - ee;
            mag = (s > 25) ? 32'd0 : ((m + (32'd1 << (s - 1))) >> s);
        end
        return neg ? (32'd0 - mag) : mag;
    endfunction

    // Exact Q1.31 to single precision, round to nearest even.
    function automatic logic [31:0] fixed_to_float(logic [31:0] s);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] m;
        logic [7:0]  e;
        int          p;
        int          r;
        neg = s[31];
        mag = neg ? (32'd0 - s) : s;
        if (mag == 32'd0)
            return 32'd0;
        p = 31;
        while (mag[p] == 1'b0)
            p = p - 1;
        e = 8'(p + 96);
        if (p <= 23) begin
            m = mag << (23 - p);
        end
        else begin
            r    = p - 23;
            rem  = mag & ((32'd1 << r) - 32'd1);
            half = 32'd1 << (r - 1);
            m    = mag >> r;
            if (rem > half || (rem == half && m[0]))
                m = m + 32'd1;
            if (m[24]) begin
                m = m >> 1;
                e = e + 8'd1;
            end
        end
        return {neg, e, m[22:0]};
    endfunction

    // Divide by 2^k rounding half away from zero, then clamp to a signed (32-k)-bit range.
    function automatic logic [31:0] round_saturate(logic [31:0] s, int k);
        longint v;
        longint half;
        longint hi;
        longint q;
        v    = longint'($signed(s));
        half = longint'(1) << (k - 1);
        hi   = (longint'(1) << (31 - k)) - 1;
        q    = (v >= 0) ? ((v + half) >>> k) : -((-v + half) >>> k);
        if (q > hi)
            q = hi;
        if (q < -hi - 1)
            q = -hi - 1;
        return q[31:0];
    endfunction

    function automatic conversion_t predict_conversion(logic o, logic [31:0] w,
                                                       logic [31:0] s, logic [2:0] f);
        conversion_t r;
        int          n;
        bit          big;
        logic [31:0] raw;
        logic [31:0] q;
        n         = bytes_per_sample(f);
        big       = (f == FMT_S16BE) || (f == FMT_S24BE) || (f == FMT_S32BE);
        r.sample_v = '0;
        r.word_v   = '0;
        r.count_v  = n[2:0];
        if (o == OP_DECODE) begin
            if (f == FMT_F32LE) begin
                r.sample_v = float_to_fixed(w);
            end
            else begin
                raw = gather_bytes(w, n, big);
                if (f == FMT_U8)
                    raw[7] = ~raw[7];
                r.sample_v = (n == 4) ? raw : (raw << (32 - 8 * n));
            end
        end
        else begin
            if (f == FMT_F32LE) begin
                r.word_v = fixed_to_float(s);
            end
            else if (n == 4) begin
                r.word_v = scatter_bytes(s, 4, big);
            end
            else begin
                q = round_saturate(s, 32 - 8 * n);
                if (f == FMT_U8)
                    q[7] = ~q[7];
                r.word_v = scatter_bytes(q, n, big);
            end
        end
        return r;
    endfunction

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
    endtask

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        conversion_t want;
        if (!rst_n) begin
            cur_format = FMT_RESET;
            pending_conversions.delete();
        end
        else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_PCM_FMT)
                cur_format = pwdata[2:0];
            if (in_valid && in_ready)
                pending_conversions.push_back(
                    predict_conversion(op, packed_in, sample_in, cur_format));
            if (out_valid && out_ready) begin
                if (pending_conversions.size() == 0) begin
                    report_mismatch("result beat with nothing pending", packed_out, '0);
                end
                else begin
                    want = pending_conversions.pop_front();
                    if (sample_out !== want.sample_v)
                        report_mismatch("sample_out", sample_out, want.sample_v);
                    if (packed_out !== want.word_v)
                        report_mismatch("packed_out", packed_out, want.word_v);
                    if (byte_count !== want.count_v)
                        report_mismatch("byte_count", {29'd0, byte_count}, {29'd0, want.count_v});
                end
            end
        end
        outstanding = pending_conversions.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the PCM sample format codec testbench: clock, reset, stimulus, flow control and verdict.
module testbench;

    import psfc_pkg::*;

    // Register index that decodes to nothing; a write there must leave the format alone.
    localparam logic REG_UNMAPPED = 1'b1;

    // Length of the one long receiver hold-off, in clock cycles.
    localparam int HOLD_LEN = 200;

    // Number of random beats to send after the directed part.
    localparam int RANDOM_BEATS = 2000;

    logic                 clk;
    logic                 rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    logic                 in_valid;
    logic                 in_ready;
    logic                 op;
    logic [31:0]          packed_in;
    logic signed [31:0]   sample_in;

    logic                 out_valid;
    logic                 out_ready;
    logic signed [31:0]   sample_out;
    logic [31:0]          packed_out;
    logic [2:0]           byte_count;

    int                   fail_count;
    int                   outstanding;

    // Shared flags between the stimulus process and the receiver process.
    // While calm is set neither side idles. Setting hold_req asks the
    // receiver to refuse beats for the long hold-off; the receiver clears it.
    bit                   calm;
    bit                   hold_req;

    int                   beats_sent;
    int                   format_writes;

    pcm_sample_format_codec dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .packed_in  (packed_in),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .packed_out (packed_out),
        .byte_count (byte_count)
    );

    pcm_codec_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .packed_in   (packed_in),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .packed_out  (packed_out),
        .byte_count  (byte_count),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Free-running clock with a period of 10 time units, starting low.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a result that never arrives ends here.
    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not reach its end in time.");
        $display("Regression FAIL");
        $finish;
    end

    // Packed input word for a format. Float words are steered half of the time
    // into exponents from 90 to 127, whose top saturates Q1.31; integer words
    // are mostly random with some all-extreme byte patterns mixed in.
    function automatic logic [31:0] random_word(logic [2:0] f);
        int          pick;
        logic [7:0]  b;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        w    = $urandom;
        if (f == FMT_F32LE) begin
            if (pick >= 35 && pick < 85)
                w[30:23] = 8'($urandom_range(90, 127));
            else if (pick >= 85 && pick < 92)
                w[30:23] = 8'hFF;
            else if (pick >= 92)
                w[30:23] = 8'h00;
        end
        else if (pick >= 80) begin
            case ($urandom_range(0, 3))
                0:       b = 8'h00;
                1:       b = 8'h7F;
                2:       b = 8'h80;
                default: b = 8'hFF;
            endcase
            w = {4{b}};
        end
        return w;
    endfunction

    // Q1.31 input sample: random, small, exact rounding ties at each integer
    // width, and values close to both ends of the range.
    function automatic logic [31:0] random_sample();
        int          pick;
        int          k;
        logic [31:0] s;
        pick = $urandom_range(0, 99);
        s    = $urandom;
        if (pick >= 40 && pick < 55) begin
            s = $urandom_range(0, 2047) - 1024;
        end
        else if (pick >= 55 && pick < 80) begin
            k = 8 * $urandom_range(1, 3);
            s = (s & ~((32'd1 << k) - 32'd1)) | (32'd1 << (k - 1));
        end
        else if (pick >= 80 && pick < 90) begin
            s = 32'h7FFF_FFFF - $urandom_range(0, 300);
        end
        else if (pick >= 90) begin
            s = 32'h8000_0000 + $urandom_range(0, 300);
        end
        return s;
    endfunction

    // Offer one input beat. Called just after a falling edge; returns just
    // after the falling edge that follows acceptance, with in_valid still
    // high so that the next beat can follow without a bubble.
    task automatic send_beat(logic o, logic [31:0] w, logic [31:0] s);
        while (!calm && $urandom_range(0, 99) < 24) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        packed_in <= w;
        sample_in <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // Two-phase register write: setup cycle, then access until pready.
    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The format may only change with nothing in flight, so stop offering
    // beats and wait until every predicted result has been received.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Upper data bits are random; only the low three bits carry the format.
    task automatic set_format(logic [2:0] f);
        wait_idle();
        apb_write({REG_PCM_FMT, 2'b00}, ($urandom & ~32'h7) | {29'd0, f});
        format_writes++;
    endtask

    // Receiver side. Mostly random back-pressure, no stalls while calm, and
    // one long hold-off on request while the sender keeps pushing, so both
    // pipeline stages fill and in_ready has to drop.
    initial
    begin
        int held;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                for (held = 1; held < HOLD_LEN; held++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else if (calm) begin
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Main stimulus and verdict.
    initial
    begin
        int         seg;
        int         len;
        int         random_sent;
        logic [2:0] f;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        op            = OP_DECODE;
        packed_in     = '0;
        sample_in     = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        beats_sent    = 0;
        format_writes = 0;
        random_sent   = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, first with the format left at its reset value of
        // s16le: full-scale decode with junk in the unused upper bytes,
        // saturating encode at both ends, and rounding ties of both signs.
        send_beat(OP_DECODE, 32'h1234_8000, $urandom);
        send_beat(OP_DECODE, 32'hFFFF_7FFF, $urandom);
        send_beat(OP_ENCODE, $urandom, 32'h7FFF_FFFF);
        send_beat(OP_ENCODE, $urandom, 32'h8000_0000);
        send_beat(OP_ENCODE, $urandom, 32'h0000_8000);
        send_beat(OP_ENCODE, $urandom, 32'hFFFF_8000);

        // A write to an unmapped register index must not change the format.
        wait_idle();
        apb_write({REG_UNMAPPED, 2'b00}, {29'd0, FMT_U8});
        send_beat(OP_DECODE, 32'h0000_0180, $urandom);

        // Unsigned 8-bit: offset of 128 on both paths, encode saturation.
        set_format(FMT_U8);
        send_beat(OP_DECODE, 32'h0000_0000, $urandom);
        send_beat(OP_DECODE, 32'hFFFF_FFFF, $urandom);
        send_beat(OP_ENCODE, $urandom, 32'h7FFF_FFFF);
        send_beat(OP_ENCODE, $urandom, 32'h8000_0000);

        // 24-bit big endian: byte order and ties at the 8-bit boundary.
        set_format(FMT_S24BE);
        send_beat(OP_DECODE, 32'h0000_0080, $urandom);
        send_beat(OP_ENCODE, $urandom, 32'h0000_0080);
        send_beat(OP_ENCODE, $urandom, 32'hFFFF_FF80);

        // 32-bit big endian passes the value through with bytes swapped.
        set_format(FMT_S32BE);
        send_beat(OP_DECODE, 32'h0102_0304, $urandom);
        send_beat(OP_ENCODE, $urandom, 32'h8000_0001);

        // Single precision: infinity and NaN give zero, magnitudes of one
        // saturate, negative zero and subnormals give zero, and a normal value of
        // half an LSB rounds half away from zero. Encode covers both range ends
        // and zero.
        set_format(FMT_F32LE);
        send_beat(OP_DECODE, 32'h7F80_0000, $urandom);
        send_beat(OP_DECODE, 32'h7FC0_0001, $urandom);
        send_beat(OP_DECODE, 32'h3F80_0000, $urandom);
        send_beat(OP_DECODE, 32'hBF80_0000, $urandom);
        send_beat(OP_DECODE, 32'h8000_0000, $urandom);
        send_beat(OP_DECODE, 32'h0000_0001, $urandom);
        send_beat(OP_DECODE, 32'h2F80_0000, $urandom);
        send_beat(OP_ENCODE, $urandom, 32'h7FFF_FFFF);
        send_beat(OP_ENCODE, $urandom, 32'h8000_0000);
        send_beat(OP_ENCODE, $urandom, 32'h0000_0000);

        // Random part in segments, one format per segment. The first eight
        // segments walk through every format; later ones pick at random.
        // Segment three starts with the long receiver hold-off, and segment
        // five runs with no idling on either side.
        seg = 0;
        while (random_sent < RANDOM_BEATS)
        begin
            f = (seg < 8) ? seg[2:0] : 3'($urandom_range(0, 7));
            set_format(f);
            calm = (seg == 5);
            if (seg == 3)
                hold_req = 1'b1;
            len = $urandom_range(100, 250);
            repeat (len)
            begin
                send_beat(1'($urandom_range(0, 1)), random_word(f), random_sample());
                random_sent++;
            end
            calm = 1'b0;
            seg++;
        end

        // Drain, then keep the clock running so that any stray result beat
        // beyond the two-stage pipeline is caught by the checker.
        wait_idle();
        repeat (8) @(negedge clk);

        $display("Sent %0d beats in both directions over %0d format writes.",
                 beats_sent, format_writes);
        $display("Covered all eight formats, a %0d-cycle receiver hold-off and no-idle traffic.",
                 HOLD_LEN);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
